FILE: src/lidar_sector_nearest_point_defines.svh
// Assertion macros shared by the checker of the sector nearest-point filter.
// No dependencies.
`ifndef LIDAR_SECTOR_NEAREST_POINT_DEFINES_SVH
`define LIDAR_SECTOR_NEAREST_POINT_DEFINES_SVH
// implication checked on every clock, held off during reset
`define LSNP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsnp check failed");
// implication whose consequent is checked on the next clock
`define LSNP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsnp check failed");
`endif

FILE: src/lsnp_pkg.sv
// Package for the lidar sector nearest-point filter: payload types, constants, CORDIC table.
// No dependencies.
package lsnp_pkg;
	localparam int MaxSectors  = 16;
	localparam int SecBits     = 4;
	localparam int CoordBits   = 20;
	localparam int AngleBits   = 16;
	localparam int DistBits    = 40;
	localparam int CordicSteps = 32;
	localparam int CordicW     = 64;
	localparam int CfgIdxBits  = 2;
	localparam int CfgDataBits = 20;
	localparam logic [4:0] DefaultSectors = 5'd12;

	localparam logic [CfgIdxBits-1:0] CfgSectorCount = 2'd0;
	localparam logic [CfgIdxBits-1:0] CfgZFloor      = 2'd1;
	localparam logic [CfgIdxBits-1:0] CfgZCeiling    = 2'd2;

	typedef struct packed {
		logic signed [CoordBits-1:0] x_mm;
		logic signed [CoordBits-1:0] y_mm;
		logic signed [CoordBits-1:0] z_mm;
		logic                        return_invalid;
		logic                        end_of_frame;
	} in_t;

	typedef struct packed {
		logic [3:0]                  sector_index;
		logic signed [CoordBits-1:0] near_x;
		logic signed [CoordBits-1:0] near_y;
		logic signed [CoordBits-1:0] near_z;
		logic                        point_found;
		logic                        last_of_frame;
	} out_t;

	// point handed from the front end to the sector store
	typedef struct packed {
		logic                        keep;
		logic                        eof;
		logic [SecBits-1:0]          sec;
		logic [DistBits-1:0]         dsq;
		logic signed [CoordBits-1:0] x;
		logic signed [CoordBits-1:0] y;
		logic signed [CoordBits-1:0] z;
	} pt_t;

	typedef struct packed {
		logic [DistBits-1:0]         dsq;
		logic signed [CoordBits-1:0] x;
		logic signed [CoordBits-1:0] y;
		logic signed [CoordBits-1:0] z;
	} entry_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;  default: r = 32'h00000000;
		endcase
		return r;
	endfunction
endpackage

FILE: src/lsnp_front.sv
// Front end: point filter, squared distance and iterative CORDIC azimuth to sector.
// Depends on lsnp_pkg.
module lsnp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  lsnp_pkg::in_t                 pt,
	input  logic [4:0]                    sector_count,
	input  logic signed [lsnp_pkg::CoordBits-1:0] z_floor,
	input  logic signed [lsnp_pkg::CoordBits-1:0] z_top,
	output logic                          busy,
	output logic                          done,
	output lsnp_pkg::pt_t                 res
);
	import lsnp_pkg::*;

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StMul  = 3'd1;
	localparam logic [2:0] StRot  = 3'd2;
	localparam logic [2:0] StFold = 3'd3;
	localparam logic [2:0] StSec  = 3'd4;

	logic [2:0]                  st_q;
	logic [4:0]                  step_q;
	logic signed [CordicW-1:0]   cx_q, cy_q, cz_q;
	logic [CoordBits-1:0]        ax_q, ay_q;
	logic [2*CoordBits-1:0]      sx_q, sy_q;
	logic [31:0]                 ang_q;
	logic [SecBits:0]            n_q;
	logic                        xneg_q, yneg_q;
	pt_t                         res_q;
	logic                        done_q;

	logic signed [CordicW-1:0]   dx, dy;
	logic signed [CordicW-1:0]   zc;
	logic [31:0]                 phi;
	logic [AngleBits+SecBits:0]  prod;
	logic [SecBits:0]            sec_raw;
	logic [4:0]                  n_eff;
	logic                        keep;
	logic [CoordBits-1:0]        absx, absy;

	assign absx = pt.x_mm[CoordBits-1] ? CoordBits'(-pt.x_mm) : CoordBits'(pt.x_mm);
	assign absy = pt.y_mm[CoordBits-1] ? CoordBits'(-pt.y_mm) : CoordBits'(pt.y_mm);
	assign keep = !pt.return_invalid && (pt.z_mm >= z_floor) && (pt.z_mm <= z_top)
		&& ((pt.x_mm != '0) || (pt.y_mm != '0));
	assign n_eff = (sector_count == 5'd0) ? DefaultSectors
		: ((sector_count > 5'(MaxSectors)) ? 5'(MaxSectors) : sector_count);

	assign dx = cy_q >>> step_q;
	assign dy = cx_q >>> step_q;

	always_comb begin
		zc = cz_q;
		if (zc < 0)
			zc = '0;
		if (zc > CordicW'(32'h40000000))
			zc = CordicW'(32'h40000000);
	end
	assign phi = zc[31:0];
	assign prod = ang_q[31:32-AngleBits] * n_q;
	assign sec_raw = prod[AngleBits+SecBits:AngleBits];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= StIdle;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				StIdle: if (start) st_q <= StMul;
				StMul:  st_q <= StRot;
				StRot:  if (step_q == 5'(CordicSteps-1)) st_q <= StFold;
				StFold: st_q <= StSec;
				StSec: begin
					st_q   <= StIdle;
					done_q <= 1'b1;
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			StIdle: if (start) begin
				res_q.keep <= keep;
				res_q.eof  <= pt.end_of_frame;
				res_q.x    <= pt.x_mm;
				res_q.y    <= pt.y_mm;
				res_q.z    <= pt.z_mm;
				ax_q       <= absx;
				ay_q       <= absy;
				xneg_q     <= pt.x_mm[CoordBits-1];
				yneg_q     <= pt.y_mm[CoordBits-1];
				n_q        <= n_eff;
			end
			StMul: begin
				sx_q   <= ax_q * ax_q;
				sy_q   <= ay_q * ay_q;
				cx_q   <= CordicW'({ax_q, 8'd0});
				cy_q   <= CordicW'({ay_q, 8'd0});
				cz_q   <= '0;
				step_q <= '0;
			end
			StRot: begin
				res_q.dsq <= DistBits'(sx_q) + DistBits'(sy_q);
				if (cy_q > 0) begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + CordicW'(atan_turn(step_q));
				end else begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - CordicW'(atan_turn(step_q));
				end
				step_q <= step_q + 5'd1;
			end
			StFold: begin
				priority if (!xneg_q && !yneg_q) ang_q <= phi;
				else if (xneg_q && !yneg_q) ang_q <= 32'h80000000 - phi;
				else if (xneg_q) ang_q <= 32'h80000000 + phi;
				else ang_q <= 32'd0 - phi;
			end
			StSec: res_q.sec <= (sec_raw >= n_q) ? SecBits'(n_q - 1'b1) : SecBits'(sec_raw);
			default: ;
		endcase
	end

	assign busy = (st_q != StIdle);
	assign done = done_q;
	assign res  = res_q;
endmodule

FILE: src/lsnp_store.sv
// Sector store: per-sector memory with read-modify-write update and frame emission scan.
// Depends on lsnp_pkg.
module lsnp_store (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          upd,
	input  lsnp_pkg::pt_t pt,
	output logic          busy,
	output logic          ovalid,
	input  logic          oready,
	output lsnp_pkg::out_t odata
);
	import lsnp_pkg::*;

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StCmp  = 3'd1;
	localparam logic [2:0] StScan = 3'd2;
	localparam logic [2:0] StRd   = 3'd3;
	localparam logic [2:0] StOut  = 3'd4;

	entry_t                  mem [MaxSectors];
	entry_t                  rd_q;
	logic [MaxSectors-1:0]   found_q;
	logic [2:0]              st_q;
	pt_t                     pt_q;
	logic [SecBits:0]        scan_q;
	logic [SecBits-1:0]      rd_addr;
	logic                    any_q;
	logic                    we;
	logic [SecBits-1:0]      cur;
	logic [MaxSectors-1:0]   rest;
	out_t                    o_q;
	logic                    ov_q;

	assign cur = scan_q[SecBits-1:0];
	assign rd_addr = (st_q == StIdle) ? pt.sec : cur;
	assign we = (st_q == StCmp) && pt_q.keep
		&& (!found_q[pt_q.sec] || (pt_q.dsq < rd_q.dsq));

	always_comb begin
		rest = '0;
		for (int i = 0; i < MaxSectors; i++)
			rest[i] = found_q[i] && (i > int'(cur));
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (we)
			mem[pt_q.sec] <= '{dsq: pt_q.dsq, x: pt_q.x, y: pt_q.y, z: pt_q.z};
		if (st_q == StIdle && upd)
			pt_q <= pt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= StIdle;
			found_q <= '0;
			scan_q  <= '0;
			any_q   <= 1'b0;
			ov_q    <= 1'b0;
			o_q     <= '0;
		end else begin
			if (ov_q && oready)
				ov_q <= 1'b0;
			unique case (st_q)
				StIdle: if (upd) st_q <= StCmp;
				StCmp: begin
					if (we)
						found_q[pt_q.sec] <= 1'b1;
					scan_q <= '0;
					any_q  <= 1'b0;
					st_q   <= pt_q.eof ? StScan : StIdle;
				end
				StScan: begin
					if (scan_q == (SecBits+1)'(MaxSectors)) begin
						if (!any_q) begin
							if (!ov_q || oready) begin
								o_q  <= '{sector_index: '0, near_x: '0, near_y: '0,
									near_z: '0, point_found: 1'b0, last_of_frame: 1'b1};
								ov_q <= 1'b1;
								st_q <= StIdle;
							end
						end else
							st_q <= StIdle;
					end else if (found_q[cur])
						st_q <= StRd;
					else
						scan_q <= scan_q + 1'b1;
				end
				StRd: st_q <= StOut;
				StOut: if (!ov_q || oready) begin
					o_q <= '{sector_index: 4'(cur), near_x: rd_q.x, near_y: rd_q.y,
						near_z: rd_q.z, point_found: 1'b1, last_of_frame: (rest == '0)};
					ov_q         <= 1'b1;
					found_q[cur] <= 1'b0;
					any_q        <= 1'b1;
					scan_q       <= scan_q + 1'b1;
					st_q         <= StScan;
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	assign busy   = (st_q != StIdle);
	assign ovalid = ov_q;
	assign odata  = o_q;
endmodule

FILE: src/lidar_sector_nearest_point.sv
// Flow: a request passes the front-end states Mul, Rot, Fold and Sec (CORDIC runs 32 iterations, one a cycle).
// A new request is taken only when front end and store are idle; end of frame adds a 16-entry scan.
// Reset: asynchronous, clears found flags, control state and config to defaults.
// Sector memory holds no reset; entries are read only after they are written.
// Depends on lsnp_pkg, lsnp_front, lsnp_store.
module lidar_sector_nearest_point (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lsnp_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output lsnp_pkg::out_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [lsnp_pkg::CfgIdxBits-1:0]  cfg_index,
	input  logic [lsnp_pkg::CfgDataBits-1:0] cfg_data
);
	import lsnp_pkg::*;

	logic [4:0]                  cnt_q;
	logic signed [CoordBits-1:0] zf_q, zc_q;
	logic                        f_busy, f_done, s_busy, start;
	pt_t                         f_res;

	assign cfg_ready = 1'b1;
	assign in_ready  = !f_busy && !f_done && !s_busy;
	assign start     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= DefaultSectors;
			zf_q  <= {1'b1, {(CoordBits-1){1'b0}}};
			zc_q  <= {1'b0, {(CoordBits-1){1'b1}}};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CfgSectorCount: cnt_q <= cfg_data[4:0];
				CfgZFloor:      zf_q  <= cfg_data;
				CfgZCeiling:    zc_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	lsnp_front u_front (
		.clk, .arst_n, .start, .pt(in_data), .sector_count(cnt_q),
		.z_floor(zf_q), .z_top(zc_q), .busy(f_busy), .done(f_done), .res(f_res)
	);

	lsnp_store u_store (
		.clk, .arst_n, .upd(f_done), .pt(f_res), .busy(s_busy),
		.ovalid(out_valid), .oready(out_ready), .odata(out_data)
	);
endmodule

FILE: src/lsnp_checker.sv
// Port-level checker for the lidar sector nearest-point filter, bound to the top level.
// Depends on lsnp_pkg and lidar_sector_nearest_point_defines.svh.
`include "lidar_sector_nearest_point_defines.svh"
module lsnp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input lsnp_pkg::out_t out_data
);
	import lsnp_pkg::*;
	`LSNP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	`LSNP_ASSERT_IMPL(a_empty_last, out_valid && !out_data.point_found, out_data.last_of_frame)
	`LSNP_ASSERT_IMPL(a_empty_zero, out_valid && !out_data.point_found,
		out_data.sector_index == '0)
	`LSNP_ASSERT_NEXT(a_no_back, in_valid && in_ready, !in_ready)
endmodule

bind lidar_sector_nearest_point lsnp_checker u_lsnp_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

FILE: tb/sv/lidar_sector_nearest_point_test.sv
// Self-checking bench for lidar_sector_nearest_point: directed table, then random frames
// checked against an in-bench sector model. Depends on lsnp_pkg and the block's RTL.
module lidar_sector_nearest_point_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lsnp_pkg::*;

	localparam logic [CfgIdxBits-1:0] CfgNoReg = 2'd3;
	localparam int WatchLimit = 5000;
	localparam int Settle = 60;
	localparam logic [31:0] AtanTab [CordicSteps] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxBits-1:0] cfg_index = '0;
	logic [CfgDataBits-1:0] cfg_data = '0;

	lidar_sector_nearest_point dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sector model state
	logic [4:0] m_count;
	logic signed [CoordBits-1:0] m_floor, m_ceil;
	logic [DistBits-1:0] m_dist [MaxSectors];
	logic signed [CoordBits-1:0] m_x [MaxSectors], m_y [MaxSectors], m_z [MaxSectors];
	logic m_found [MaxSectors];
	out_t nearest_q [$];

	int errors = 0;
	int burst = 0;
	int idle_cnt = 0;

	typedef struct {
		in_t pt;
		bit typed;
		out_t res;
	} row_t;

	function automatic logic [31:0] quadrant_angle(longint ax, longint ay);
		longint x, y, z, dx, dy;
		x = ax <<< 8;
		y = ay <<< 8;
		z = 0;
		for (int i = 0; i < CordicSteps; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += longint'(AtanTab[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(AtanTab[i]);
			end
		end
		if (z < 0) z = 0;
		if (z > 64'h40000000) z = 64'h40000000;
		return z[31:0];
	endfunction

	function automatic logic [31:0] azimuth(longint x, longint y);
		logic [31:0] phi;
		phi = quadrant_angle(x < 0 ? -x : x, y < 0 ? -y : y);
		if (x >= 0 && y >= 0) return phi;
		if (x < 0 && y >= 0) return 32'h80000000 - phi;
		if (x < 0) return 32'h80000000 + phi;
		return 32'h0 - phi;
	endfunction

	// updates the sector model and, when push is set, queues the results of a frame end
	task automatic predict_point(in_t p, bit push);
		longint x, y, z;
		longint unsigned n, ang, sec, d;
		out_t r;
		int hits;
		x = p.x_mm; y = p.y_mm; z = p.z_mm;
		n = (m_count == 0) ? DefaultSectors : m_count;
		if (n > MaxSectors) n = MaxSectors;
		if (!p.return_invalid && z >= m_floor && z <= m_ceil && (x != 0 || y != 0)) begin
			d = x * x + y * y;
			ang = azimuth(x, y) >> 16;
			sec = (ang * n) >> AngleBits;
			if (sec >= n) sec = n - 1;
			if (!m_found[sec] || d < m_dist[sec]) begin
				m_found[sec] = 1'b1;
				m_dist[sec] = d[DistBits-1:0];
				m_x[sec] = p.x_mm; m_y[sec] = p.y_mm; m_z[sec] = p.z_mm;
			end
		end
		if (!p.end_of_frame) return;
		hits = 0;
		for (int s = 0; s < MaxSectors; s++) begin
			if (m_found[s]) begin
				r.sector_index = s[3:0];
				r.near_x = m_x[s]; r.near_y = m_y[s]; r.near_z = m_z[s];
				r.point_found = 1'b1; r.last_of_frame = 1'b0;
				if (push) nearest_q.insert(nearest_q.size(), r);
				hits++;
				m_found[s] = 1'b0;
			end
		end
		if (!push) return;
		if (hits == 0) begin
			r = '{default: '0, last_of_frame: 1'b1};
			nearest_q.insert(nearest_q.size(), r);
		end else
			nearest_q[$].last_of_frame = 1'b1;
	endtask

	function automatic int draw_gap();
		if (burst) return 0;
		return $urandom_range(0, 17);
	endfunction

	task automatic send_point(in_t p);
		int gap;
		gap = draw_gap();
		if (gap > 0 && in_valid) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		if (in_valid) in_valid <= 1'b0;
		while (nearest_q.size() != 0) @(posedge clk);
		repeat (Settle) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CfgSectorCount: m_count = val[4:0];
			CfgZFloor:      m_floor = val;
			CfgZCeiling:    m_ceil = val;
			default: ;
		endcase
	endtask

	function automatic logic signed [CoordBits-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0, 1: return CoordBits'($urandom());
			2, 3: return CoordBits'(int'($urandom_range(0, 2000)) - 1000);
			4: return $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
			default: return '0;
		endcase
	endfunction

	function automatic in_t rand_point();
		in_t p;
		longint span;
		p.x_mm = rand_coord();
		p.y_mm = rand_coord();
		span = longint'(m_ceil) - longint'(m_floor);
		if (span >= 0 && $urandom_range(0, 4) != 0)
			p.z_mm = CoordBits'(longint'(m_floor)
				+ longint'($urandom_range(0, 32'(span > 2000000 ? 2000000 : span))));
		else
			p.z_mm = CoordBits'($urandom());
		p.return_invalid = ($urandom_range(0, 9) == 0);
		p.end_of_frame = ($urandom_range(0, 7) == 0);
		return p;
	endfunction

	initial begin
		row_t rows [$];
		logic [4:0] counts [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd3};
		logic signed [CoordBits-1:0] floors [6] = '{20'sh80000, -20'sd100, '0, 20'sd5,
			20'sh80000, -20'sd50000};
		logic signed [CoordBits-1:0] ceils [6] = '{20'sh7FFFF, 20'sd100, '0, -20'sd5,
			20'sh7FFFF, 20'sd50000};
		in_t p;
		m_count = DefaultSectors;
		m_floor = 20'sh80000;
		m_ceil = 20'sh7FFFF;
		foreach (m_found[i]) m_found[i] = 1'b0;

		rows.insert(rows.size(), '{'{0, 0, 0, 0, 1}, 1, '{0, 0, 0, 0, 0, 1}});
		rows.insert(rows.size(), '{'{1, 0, 0, 0, 1}, 1, '{0, 1, 0, 0, 1, 1}});
		rows.insert(rows.size(), '{'{7, 7, 0, 1, 1}, 1, '{0, 0, 0, 0, 0, 1}});
		rows.insert(rows.size(), '{'{0, 0, 9, 0, 1}, 1, '{0, 0, 0, 0, 0, 1}});
		rows.insert(rows.size(), '{'{20'sh80000, 20'sh80000, 20'sh80000, 0, 0}, 0, '0});
		rows.insert(rows.size(), '{'{20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 0, 0}, 0, '0});
		rows.insert(rows.size(), '{'{20'sh7FFFF, 20'sh80000, 0, 0, 0}, 0, '0});
		rows.insert(rows.size(), '{'{20'sh80000, 20'sh7FFFF, 0, 0, 1}, 0, '0});
		rows.insert(rows.size(), '{'{3, 4, 1, 0, 0}, 0, '0});
		rows.insert(rows.size(), '{'{3, 4, 2, 0, 0}, 0, '0});
		rows.insert(rows.size(), '{'{0, 5, 0, 0, 0}, 0, '0});
		rows.insert(rows.size(), '{'{-5, 0, 0, 0, 0}, 0, '0});
		rows.insert(rows.size(), '{'{0, -5, 0, 0, 0}, 0, '0});
		rows.insert(rows.size(), '{'{5, -1, 0, 0, 0}, 0, '0});
		rows.insert(rows.size(), '{'{2, 2, 0, 0, 1}, 0, '0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_point(rows[i].pt);
			predict_point(rows[i].pt, !rows[i].typed);
			if (rows[i].typed) nearest_q.insert(nearest_q.size(), rows[i].res);
		end

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			write_reg(CfgSectorCount, {15'd0, counts[ph]});
			write_reg(CfgZFloor, floors[ph]);
			write_reg(CfgZCeiling, ceils[ph]);
			if (ph == 4) write_reg(CfgNoReg, 20'hFFFFF);
			cfg_valid <= 1'b0;
			burst = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < 25; k++) begin
				p = rand_point();
				if (k == 24) p.end_of_frame = (ph == 4) ? 1'b0 : $urandom_range(0, 1);
				send_point(p);
				predict_point(p, 1);
			end
		end
		p = '{default: '0, x_mm: 20'sd10, end_of_frame: 1'b1};
		send_point(p);
		predict_point(p, 1);
		in_valid <= 1'b0;

		while (nearest_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("lidar_sector_nearest_point: match");
		else $display("lidar_sector_nearest_point: mismatch");
		$finish;
	end

	initial begin
		out_t want;
		int stall;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			if (stall > 0 && out_ready) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (nearest_q.size() == 0) begin
				$error("unexpected result sector_index %0d", out_data.sector_index);
				errors++;
			end else begin
				want = nearest_q.pop_front();
				if (out_data.sector_index !== want.sector_index) begin
					$error("sector_index exp %0d got %0d", want.sector_index,
						out_data.sector_index);
					errors++;
				end
				if (out_data.near_x !== want.near_x) begin
					$error("near_x exp %0d got %0d", want.near_x, out_data.near_x);
					errors++;
				end
				if (out_data.near_y !== want.near_y) begin
					$error("near_y exp %0d got %0d", want.near_y, out_data.near_y);
					errors++;
				end
				if (out_data.near_z !== want.near_z) begin
					$error("near_z exp %0d got %0d", want.near_z, out_data.near_z);
					errors++;
				end
				if (out_data.point_found !== want.point_found) begin
					$error("point_found exp %0d got %0d", want.point_found,
						out_data.point_found);
					errors++;
				end
				if (out_data.last_of_frame !== want.last_of_frame) begin
					$error("last_of_frame exp %0d got %0d", want.last_of_frame,
						out_data.last_of_frame);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WatchLimit) begin
			$display("lidar_sector_nearest_point: mismatch");
			$finish;
		end
	end
endmodule
